>>> sv/cmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_pkg
// shared types and constants of the colour matrix converter: register map,
// reset values, configuration and framing structs
// ----------------------------------------------------------------------------
package cmc_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int COEFF_W  = 16;
  localparam int ROW_W    = 3 * COEFF_W;
  localparam int GEOM_W   = 14;
  localparam int COUNT_W  = 13;
  localparam int APB_DW   = 64;
  localparam int APB_AW   = 6;
  localparam int REG_SEL_LSB = 3;
  localparam int REG_SEL_W   = 3;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_COEFF_ZERO = 3'd0,
    REG_COEFF_ONE  = 3'd1,
    REG_COEFF_TWO  = 3'd2,
    REG_OFFSET     = 3'd3,
    REG_WIDTH      = 3'd4,
    REG_HEIGHT     = 3'd5
  } reg_idx_e;

  localparam logic [ROW_W-1:0]  COEFF_ZERO_RST = 48'h0000_0000_0100;
  localparam logic [ROW_W-1:0]  COEFF_ONE_RST  = 48'h0000_0100_0000;
  localparam logic [ROW_W-1:0]  COEFF_TWO_RST  = 48'h0100_0000_0000;
  localparam logic [ROW_W-1:0]  OFFSET_RST     = 48'h0;
  localparam logic [GEOM_W-1:0] WIDTH_RST      = 14'd1920;
  localparam logic [GEOM_W-1:0] HEIGHT_RST     = 14'd1080;
  localparam logic [GEOM_W-1:0] GEOM_MAX       = 14'd8192;

  typedef struct packed {
    logic [2:0][ROW_W-1:0] coeff;
    logic [ROW_W-1:0]      offset;
    logic [GEOM_W-1:0]     line_width;
    logic [GEOM_W-1:0]     frame_height;
  } cfg_t;

  typedef struct packed {
    logic sof;
    logic eol;
  } frame_flags_t;

endpackage

>>> sv/cmc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_pix_in_if / cmc_pix_out_if
// valid/ready pixel channels into and out of the colour matrix converter
// ----------------------------------------------------------------------------
interface cmc_pix_in_if
  import cmc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] in_chan_zero;
  logic [CHANNEL_BITS-1:0] in_chan_one;
  logic [CHANNEL_BITS-1:0] in_chan_two;

  modport source (output valid, in_chan_zero, in_chan_one, in_chan_two, input ready);
  modport sink   (input valid, in_chan_zero, in_chan_one, in_chan_two, output ready);
endinterface

interface cmc_pix_out_if
  import cmc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] out_chan_zero;
  logic [CHANNEL_BITS-1:0] out_chan_one;
  logic [CHANNEL_BITS-1:0] out_chan_two;
  logic                    start_of_frame;
  logic                    end_of_line;

  modport source (output valid, out_chan_zero, out_chan_one, out_chan_two,
                  start_of_frame, end_of_line, input ready);
  modport sink   (input valid, out_chan_zero, out_chan_one, out_chan_two,
                  start_of_frame, end_of_line, output ready);
endinterface

>>> sv/color_matrix_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_matrix_convert
// 3x3 affine colour-space conversion on a pixel stream with frame markers
//
//   port      dir   handshake        carries
//   pix_i     in    valid / ready    three input samples
//   pix_o     out   valid / ready    three clamped samples, sof, eol
//   apb       in    psel / penable   coefficient, offset and geometry regs
//
// one item per clock sustained while pix_o is not stalled; input register then
// result register, with the matrix arithmetic between them
// reset clears the pipeline valids, counters and registers to defaults
// a stalled result holds in the result register while the input register
// still takes one more item; ready follows the downstream stall combinationally
// ----------------------------------------------------------------------------
module color_matrix_convert
  import cmc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)(
  input  logic                clk_i,
  input  logic                rst_ni,
  cmc_pix_in_if.sink          pix_i,
  cmc_pix_out_if.source       pix_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  cfg_t                           cfg;
  frame_flags_t                   flags;
  logic                           in_acc;
  logic                           adv2;
  logic                           v1_q, v2_q;
  logic [2:0][CHANNEL_BITS-1:0]   smp1_q;
  frame_flags_t                   flags1_q, flags2_q;
  logic [2:0][CHANNEL_BITS-1:0]   res;
  logic [2:0][CHANNEL_BITS-1:0]   res2_q;

  cmc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cmc_framer u_framer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_acc),
    .line_width_i   (cfg.line_width),
    .frame_height_i (cfg.frame_height),
    .flags_o        (flags)
  );

  for (genvar c = 0; c < 3; c++) begin : g_chan
    cmc_channel #(
      .CHANNEL_BITS (CHANNEL_BITS)
    ) u_chan (
      .smp_i    (smp1_q),
      .coeff_i  (cfg.coeff[c]),
      .offset_i (cfg.offset[COEFF_W*c +: COEFF_W]),
      .res_o    (res[c])
    );
  end

  assign adv2        = !v2_q || pix_o.ready;
  assign pix_i.ready = !v1_q || adv2;
  assign in_acc      = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (pix_i.ready) v1_q <= pix_i.valid;
      if (adv2)        v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp1_q   <= {pix_i.in_chan_two, pix_i.in_chan_one, pix_i.in_chan_zero};
      flags1_q <= flags;
    end
    if (adv2 && v1_q) begin
      res2_q   <= res;
      flags2_q <= flags1_q;
    end
  end

  assign pix_o.valid          = v2_q;
  assign pix_o.out_chan_zero  = res2_q[0];
  assign pix_o.out_chan_one   = res2_q[1];
  assign pix_o.out_chan_two   = res2_q[2];
  assign pix_o.start_of_frame = flags2_q.sof;
  assign pix_o.end_of_line    = flags2_q.eol;

endmodule

>>> sv/cmc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_regs
// apb register file: coefficient rows, offsets and frame geometry
// ----------------------------------------------------------------------------
module cmc_regs
  import cmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_idx_e'(paddr[REG_SEL_LSB +: REG_SEL_W]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coeff[0]     <= COEFF_ZERO_RST;
      cfg_q.coeff[1]     <= COEFF_ONE_RST;
      cfg_q.coeff[2]     <= COEFF_TWO_RST;
      cfg_q.offset       <= OFFSET_RST;
      cfg_q.line_width   <= WIDTH_RST;
      cfg_q.frame_height <= HEIGHT_RST;
    end else if (wr_en) begin
      case (sel)
        REG_COEFF_ZERO: cfg_q.coeff[0]     <= pwdata[ROW_W-1:0];
        REG_COEFF_ONE:  cfg_q.coeff[1]     <= pwdata[ROW_W-1:0];
        REG_COEFF_TWO:  cfg_q.coeff[2]     <= pwdata[ROW_W-1:0];
        REG_OFFSET:     cfg_q.offset       <= pwdata[ROW_W-1:0];
        REG_WIDTH:      cfg_q.line_width   <= pwdata[GEOM_W-1:0];
        REG_HEIGHT:     cfg_q.frame_height <= pwdata[GEOM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (sel)
      REG_COEFF_ZERO: prdata = {{(APB_DW-ROW_W){1'b0}}, cfg_q.coeff[0]};
      REG_COEFF_ONE:  prdata = {{(APB_DW-ROW_W){1'b0}}, cfg_q.coeff[1]};
      REG_COEFF_TWO:  prdata = {{(APB_DW-ROW_W){1'b0}}, cfg_q.coeff[2]};
      REG_OFFSET:     prdata = {{(APB_DW-ROW_W){1'b0}}, cfg_q.offset};
      REG_WIDTH:      prdata = {{(APB_DW-GEOM_W){1'b0}}, cfg_q.line_width};
      REG_HEIGHT:     prdata = {{(APB_DW-GEOM_W){1'b0}}, cfg_q.frame_height};
      default:        prdata = '0;
    endcase
  end

endmodule

>>> sv/cmc_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_framer
// column and row counters giving start-of-frame and end-of-line per item
// ----------------------------------------------------------------------------
module cmc_framer
  import cmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [GEOM_W-1:0] line_width_i,
  input  logic [GEOM_W-1:0] frame_height_i,
  output frame_flags_t      flags_o
);

  logic [COUNT_W-1:0] col_q, col_d;
  logic [COUNT_W-1:0] row_q, row_d;
  logic [COUNT_W-1:0] col_last, row_last;
  logic               last_row;

  // last position of a dimension, zero acting as one and large values clipped
  function automatic logic [COUNT_W-1:0] last_pos(input logic [GEOM_W-1:0] v);
    logic [GEOM_W-1:0] m1;
    m1 = v - 1'b1;
    if (v == '0)
      last_pos = '0;
    else if (v > GEOM_MAX)
      last_pos = '1;
    else
      last_pos = m1[COUNT_W-1:0];
  endfunction

  assign col_last    = last_pos(line_width_i);
  assign row_last    = last_pos(frame_height_i);
  assign flags_o.eol = (col_q >= col_last);
  assign flags_o.sof = (col_q == '0) && (row_q == '0);
  assign last_row    = (row_q >= row_last);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (flags_o.eol) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  a_eol_wraps_column : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && flags_o.eol |=> col_q == '0)
    else $error("column counter not cleared after end of line");

  a_column_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !flags_o.eol |=> col_q == $past(col_q) + 1'b1 && row_q == $past(row_q))
    else $error("column counter did not step by one");

  a_sof_row_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && flags_o.sof && !flags_o.eol |=> row_q == '0 && !flags_o.sof)
    else $error("first line left too early");

endmodule

>>> sv/cmc_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_channel
// one output channel: three-tap q8.8 dot product, floor shift, offset, clamp
// ----------------------------------------------------------------------------
module cmc_channel
  import cmc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)(
  input  logic [2:0][CHANNEL_BITS-1:0] smp_i,
  input  logic [ROW_W-1:0]             coeff_i,
  input  logic [COEFF_W-1:0]           offset_i,
  output logic [CHANNEL_BITS-1:0]      res_o
);

  localparam int PW = COEFF_W + CHANNEL_BITS + 1;
  localparam int SW = PW + 2;
  localparam int RW = SW + 1;

  logic signed [PW-1:0] prod [3];
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] shifted;
  logic signed [RW-1:0] biased;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = $signed({{(PW-COEFF_W){coeff_i[COEFF_W*k+COEFF_W-1]}},
                         coeff_i[COEFF_W*k +: COEFF_W]})
              * $signed({{(PW-CHANNEL_BITS){1'b0}}, smp_i[k]});
    end
  end

  assign sum     = $signed({{2{prod[0][PW-1]}}, prod[0]})
                 + $signed({{2{prod[1][PW-1]}}, prod[1]})
                 + $signed({{2{prod[2][PW-1]}}, prod[2]});
  // arithmetic shift floors towards minus infinity
  assign shifted = sum >>> 8;
  assign biased  = $signed({shifted[SW-1], shifted})
                 + $signed({{(RW-COEFF_W){offset_i[COEFF_W-1]}}, offset_i});

  always_comb begin
    if (biased[RW-1])
      res_o = '0;
    else if (|biased[RW-2:CHANNEL_BITS])
      res_o = '1;
    else
      res_o = biased[CHANNEL_BITS-1:0];
  end

endmodule
